FILE: rtl/core/huffman_zero_run_bit_packer_unit_macros.svh
// Assertion macros for the zero-run Huffman bit packer RTL
`ifndef HUFFMAN_ZERO_RUN_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_ZERO_RUN_BIT_PACKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ZRBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("zero-run packer check failed");

// Consequent must hold in the cycle after the antecedent
`define ZRBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zero-run packer check failed");

`endif

FILE: rtl/core/zrbp_pkg.sv
// Shared types and constants of the zero-run Huffman bit packer
`timescale 1ns / 1ps
package zrbp_pkg;

  localparam int RUN_W     = 15;  // zero run counter width
  localparam int OFF_W     = 14;  // widest run offset field
  localparam int OFF_LEN_W = 4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Code table slots used by zero runs
  localparam logic [8:0] SLOT_ZERO      = 9'd0;
  localparam logic [8:0] SLOT_RUN_PAIR  = 9'd256;
  localparam logic [8:0] SLOT_RUN_SHORT = 9'd257;
  localparam logic [8:0] SLOT_RUN_MID   = 9'd258;
  localparam logic [8:0] SLOT_RUN_LONG  = 9'd259;
  localparam logic [8:0] SLOT_RUN_HUGE  = 9'd260;

  // Run class boundaries
  localparam logic [RUN_W-1:0] RUN_ONE        = 15'd1;
  localparam logic [RUN_W-1:0] RUN_TWO        = 15'd2;
  localparam logic [RUN_W-1:0] RUN_BASE_SHORT = 15'd3;
  localparam logic [RUN_W-1:0] RUN_BASE_MID   = 15'd7;
  localparam logic [RUN_W-1:0] RUN_BASE_LONG  = 15'd23;
  localparam logic [RUN_W-1:0] RUN_BASE_HUGE  = 15'd279;

  // Offset bit counts per run class
  localparam logic [OFF_LEN_W-1:0] OFF_LEN_NONE  = 4'd0;
  localparam logic [OFF_LEN_W-1:0] OFF_LEN_SHORT = 4'd2;
  localparam logic [OFF_LEN_W-1:0] OFF_LEN_MID   = 4'd4;
  localparam logic [OFF_LEN_W-1:0] OFF_LEN_LONG  = 4'd8;
  localparam logic [OFF_LEN_W-1:0] OFF_LEN_HUGE  = 4'd14;

  typedef struct packed {
    logic        mode;
    logic [8:0]  table_index;
    logic [31:0] code_value;
    logic [5:0]  code_length;
    logic [7:0]  data_byte;
    logic        end_of_block;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

endpackage

FILE: rtl/core/zrbp_code_mem.sv
// Code table RAM: one write port, two registered read ports
`timescale 1ns / 1ps
module zrbp_code_mem #(
  parameter int DEPTH = 261,
  parameter int AW    = 9,
  parameter int DW    = 38
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: rtl/core/zrbp_drain.sv
// Bit accumulator and output byte register
`timescale 1ns / 1ps
module zrbp_drain
  import zrbp_pkg::*;
#(
  parameter int CW  = 78,
  parameter int CLW = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           chunk_valid,
  output logic           chunk_ready,
  input  logic [CW-1:0]  chunk_bits,
  input  logic [CLW-1:0] chunk_len,
  input  logic           chunk_eob,
  output logic           out_valid,
  input  logic           out_ready,
  output out_item_t      out_data
);

  localparam int ACC_W = CW + 7;
  localparam int ACW   = $clog2(ACC_W + 1);

  logic [ACC_W-1:0] acc_r, acc_nxt, acc_a;
  logic [ACW-1:0]   cnt_r, cnt_nxt, cnt_a;
  logic             fin_r, fin_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             slot_free, can_emit, emit, done_a, merge;

  assign slot_free = !out_valid_r || out_ready;
  assign can_emit  = (cnt_r >= ACW'(8)) || (fin_r && cnt_r != '0);
  assign emit      = can_emit && slot_free;

  always_comb begin
    acc_a = acc_r;
    cnt_a = cnt_r;
    if (emit) begin
      acc_a = acc_r >> 8;
      cnt_a = (cnt_r >= ACW'(8)) ? cnt_r - ACW'(8) : '0;
    end
  end

  // take the next transaction once no full byte and no pad byte is left
  assign done_a      = (cnt_a < ACW'(8)) && !(fin_r && cnt_a != '0);
  assign chunk_ready = done_a;
  assign merge       = chunk_valid && done_a;

  always_comb begin
    acc_nxt = acc_a;
    cnt_nxt = cnt_a;
    fin_nxt = fin_r;
    if (merge) begin
      acc_nxt = acc_a | (ACC_W'(chunk_bits) << cnt_a[2:0]);
      cnt_nxt = cnt_a + ACW'(chunk_len);
      fin_nxt = chunk_eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_byte <= acc_r[7:0];
      out_data_r.out_last <= fin_r && cnt_a == '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/huffman_zero_run_bit_packer_unit.sv
// Top level of the zero-run Huffman encoder with LSB-first bit packer
`timescale 1ns / 1ps
// The block takes one transaction per cycle while in_ready is high: a code table
// load (mode 0) or a data byte (mode 1). A data byte reads its code and the code of
// any zero run it closes from the table RAM, the codes are joined over two more
// stages, and the bits enter an accumulator that drains one output byte per cycle
// while out_ready is high. A data byte is therefore taken every cycle as long as each
// one yields at most one output byte on average and the output is not stalled; bytes
// that yield more hold the input back once the pipeline is full. The first output
// byte passes the stage 1 table read, the stage 2 and 3 registers and the drain
// accumulator. Loads produce no output. The table has no reset and no clearing pass:
// every slot that will be used must be loaded before data bytes arrive.
`include "huffman_zero_run_bit_packer_unit_macros.svh"
module huffman_zero_run_bit_packer_unit
  import zrbp_pkg::*;
#(
  parameter int TABLE_DEPTH   = 261,
  parameter int MAX_CODE_BITS = 32,
  parameter int MAX_ZERO_RUN  = 16662
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int LW  = $clog2(MAX_CODE_BITS + 1);
  localparam int EW  = MAX_CODE_BITS + LW;
  localparam int RW  = MAX_CODE_BITS + OFF_W;
  localparam int RLW = $clog2(RW + 1);
  localparam int CW  = 2 * MAX_CODE_BITS + OFF_W;
  localparam int CLW = $clog2(CW + 1);

  // ---------------- accept stage ----------------
  logic                 s0_fire, is_data, byte_nz, flush_en;
  logic                 s1_free, s2_free, s3_free, chunk_ready;
  logic [RUN_W-1:0]     run_r, run_nxt, run_inc, flush_cnt;
  logic [8:0]           run_slot;
  logic [OFF_W-1:0]     off_val;
  logic [OFF_LEN_W-1:0] off_len;
  logic                 load_en;
  logic [LW-1:0]        sat_len;
  logic [MAX_CODE_BITS-1:0] code_masked;

  assign s0_fire = in_valid && in_ready;
  assign is_data = in_data.mode == MODE_DATA;
  assign byte_nz = in_data.data_byte != 8'd0;
  assign run_inc = run_r + RUN_W'(1);
  assign flush_cnt = byte_nz ? run_r : run_inc;

  always_comb begin
    if (byte_nz) begin
      flush_en = run_r != '0;
      run_nxt  = '0;
    end else if (run_inc == RUN_W'(MAX_ZERO_RUN) || in_data.end_of_block) begin
      flush_en = 1'b1;
      run_nxt  = '0;
    end else begin
      flush_en = 1'b0;
      run_nxt  = run_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (s0_fire && is_data) begin
      run_r <= run_nxt;
    end
  end

  // pick the run class slot and its offset field
  always_comb begin
    if (flush_cnt == RUN_ONE) begin
      run_slot = SLOT_ZERO;
      off_val  = '0;
      off_len  = OFF_LEN_NONE;
    end else if (flush_cnt == RUN_TWO) begin
      run_slot = SLOT_RUN_PAIR;
      off_val  = '0;
      off_len  = OFF_LEN_NONE;
    end else if (flush_cnt < RUN_BASE_MID) begin
      run_slot = SLOT_RUN_SHORT;
      off_val  = OFF_W'(flush_cnt - RUN_BASE_SHORT);
      off_len  = OFF_LEN_SHORT;
    end else if (flush_cnt < RUN_BASE_LONG) begin
      run_slot = SLOT_RUN_MID;
      off_val  = OFF_W'(flush_cnt - RUN_BASE_MID);
      off_len  = OFF_LEN_MID;
    end else if (flush_cnt < RUN_BASE_HUGE) begin
      run_slot = SLOT_RUN_LONG;
      off_val  = OFF_W'(flush_cnt - RUN_BASE_LONG);
      off_len  = OFF_LEN_LONG;
    end else begin
      run_slot = SLOT_RUN_HUGE;
      off_val  = OFF_W'(flush_cnt - RUN_BASE_HUGE);
      off_len  = OFF_LEN_HUGE;
    end
  end

  // table load: saturate the length, drop code bits above it
  assign load_en = s0_fire && in_data.mode == MODE_LOAD &&
                   ({1'b0, in_data.table_index} < 10'(TABLE_DEPTH));
  assign sat_len = (in_data.code_length > 6'(MAX_CODE_BITS)) ?
                   LW'(MAX_CODE_BITS) : LW'(in_data.code_length);

  always_comb begin
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      code_masked[i] = in_data.code_value[i] && (i < int'(sat_len));
    end
  end

  logic [EW-1:0] rd_run, rd_byte;

  zrbp_code_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_code_mem (
    .clk       (clk),
    .wr_en     (load_en),
    .wr_addr   (AW'(in_data.table_index)),
    .wr_data   ({sat_len, code_masked}),
    .rd_en     (s0_fire && is_data),
    .rd_addr_a (AW'(run_slot)),
    .rd_addr_b (AW'(in_data.data_byte)),
    .rd_data_a (rd_run),
    .rd_data_b (rd_byte)
  );

  // ---------------- stage 1: table data ready ----------------
  logic                 v1_r, flush1_r, byte1_r, eob1_r;
  logic [OFF_W-1:0]     off1_r;
  logic [OFF_LEN_W-1:0] offlen1_r;
  logic [RW-1:0]        run_bits1;
  logic [RLW-1:0]       run_len1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s0_fire && is_data) begin
      v1_r <= 1'b1;
    end else if (s2_free) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire && is_data) begin
      flush1_r  <= flush_en;
      byte1_r   <= byte_nz;
      eob1_r    <= in_data.end_of_block;
      off1_r    <= off_val;
      offlen1_r <= off_len;
    end
  end

  always_comb begin
    if (flush1_r) begin
      run_bits1 = RW'(rd_run[MAX_CODE_BITS-1:0]) |
                  (RW'(off1_r) << rd_run[EW-1:MAX_CODE_BITS]);
      run_len1  = RLW'(rd_run[EW-1:MAX_CODE_BITS]) + RLW'(offlen1_r);
    end else begin
      run_bits1 = '0;
      run_len1  = '0;
    end
  end

  // ---------------- stage 2: join run part and byte code ----------------
  logic                     v2_r, eob2_r;
  logic [RW-1:0]            run_bits2_r;
  logic [RLW-1:0]           run_len2_r;
  logic [MAX_CODE_BITS-1:0] bcode2_r;
  logic [LW-1:0]            blen2_r;
  logic [CW-1:0]            chunk2;
  logic [CLW-1:0]           chunk_len2;

  assign s1_free  = !v1_r || s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_free) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && s2_free) begin
      run_bits2_r <= run_bits1;
      run_len2_r  <= run_len1;
      bcode2_r    <= byte1_r ? rd_byte[MAX_CODE_BITS-1:0] : '0;
      blen2_r     <= byte1_r ? rd_byte[EW-1:MAX_CODE_BITS] : '0;
      eob2_r      <= eob1_r;
    end
  end

  assign chunk2     = CW'(run_bits2_r) | (CW'(bcode2_r) << run_len2_r);
  assign chunk_len2 = CLW'(run_len2_r) + CLW'(blen2_r);

  // ---------------- stage 3: chunk register ----------------
  logic           v3_r, eob3_r;
  logic [CW-1:0]  chunk_r;
  logic [CLW-1:0] chunk_len_r;

  assign s3_free = !v3_r || chunk_ready;
  assign s2_free = !v2_r || s3_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (s3_free) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && s3_free) begin
      chunk_r     <= chunk2;
      chunk_len_r <= chunk_len2;
      eob3_r      <= eob2_r;
    end
  end

  zrbp_drain #(
    .CW  (CW),
    .CLW (CLW)
  ) u_drain (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_valid (v3_r),
    .chunk_ready (chunk_ready),
    .chunk_bits  (chunk_r),
    .chunk_len   (chunk_len_r),
    .chunk_eob   (eob3_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // ---------------- assertions ----------------
  `ZRBP_ASSERT_NOW(a_run_below_cap, clk, rst_n, 1'b1, run_r < RUN_W'(MAX_ZERO_RUN))
  `ZRBP_ASSERT_NEXT(a_data_enters_s1, clk, rst_n, s0_fire && is_data, v1_r)
  `ZRBP_ASSERT_NEXT(a_chunk_holds, clk, rst_n, v3_r && !chunk_ready, v3_r && $stable(chunk_r) && $stable(chunk_len_r) && $stable(eob3_r))

endmodule

FILE: tb/zero_run_code_checker.sv
// Checker for the zero-run Huffman bit packer: predicts packed bytes and compares them
`timescale 1ns / 1ps
module zero_run_code_checker
  import zrbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        exp_left,
  output int        bytes_checked
);

  localparam int TABLE_SLOTS   = 261;
  localparam int CODE_BITS_MAX = 32;
  localparam int RUN_CAP       = 16662;

  logic [31:0] sym_code [0:TABLE_SLOTS-1];
  int          sym_len  [0:TABLE_SLOTS-1];
  int          run_len  = 0;
  logic [6:0]  bit_hold = '0;
  logic [2:0]  bit_cnt  = '0;

  out_item_t   step_buf [0:15];
  int          step_n;
  out_item_t   exp_bytes [$];

  function automatic logic [63:0] low_ones(input int len);
    return (64'd1 << len) - 64'd1;
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    if (step_n < 16) begin
      step_buf[step_n] = r;
      step_n++;
    end
  endtask

  task automatic pack_bits(input logic [31:0] value, input int len);
    logic [63:0] acc;
    int          cnt;
    if (len > CODE_BITS_MAX) len = CODE_BITS_MAX;
    acc = {57'd0, bit_hold} | (({32'd0, value} & low_ones(len)) << bit_cnt);
    cnt = bit_cnt + len;
    while (cnt >= 8) begin
      emit_byte(acc[7:0]);
      acc = acc >> 8;
      cnt -= 8;
    end
    bit_hold = acc[6:0];
    bit_cnt  = cnt[2:0];
  endtask

  task automatic code_symbol(input int slot);
    pack_bits(sym_code[slot], sym_len[slot]);
  endtask

  // Code the open zero run by its length class, then clear it
  task automatic close_run();
    if (run_len != 0) begin
      if (run_len == RUN_ONE) begin
        code_symbol(SLOT_ZERO);
      end else if (run_len == RUN_TWO) begin
        code_symbol(SLOT_RUN_PAIR);
      end else if (run_len < RUN_BASE_MID) begin
        code_symbol(SLOT_RUN_SHORT);
        pack_bits(run_len - RUN_BASE_SHORT, OFF_LEN_SHORT);
      end else if (run_len < RUN_BASE_LONG) begin
        code_symbol(SLOT_RUN_MID);
        pack_bits(run_len - RUN_BASE_MID, OFF_LEN_MID);
      end else if (run_len < RUN_BASE_HUGE) begin
        code_symbol(SLOT_RUN_LONG);
        pack_bits(run_len - RUN_BASE_LONG, OFF_LEN_LONG);
      end else begin
        code_symbol(SLOT_RUN_HUGE);
        pack_bits(run_len - RUN_BASE_HUGE, OFF_LEN_HUGE);
      end
      run_len = 0;
    end
  endtask

  task automatic predict_item(input in_item_t it);
    int        l;
    out_item_t r;
    step_n = 0;
    if (it.mode == MODE_LOAD) begin
      if (it.table_index < TABLE_SLOTS) begin
        l = it.code_length;
        if (l > CODE_BITS_MAX) l = CODE_BITS_MAX;
        sym_len[it.table_index]  = l;
        sym_code[it.table_index] = it.code_value & 32'(low_ones(l));
      end
    end else begin
      if (it.data_byte != 8'd0) begin
        close_run();
        code_symbol(it.data_byte);
      end else begin
        run_len++;
        if (run_len >= RUN_CAP) close_run();
      end
      if (it.end_of_block) begin
        close_run();
        if (bit_cnt != 3'd0) begin
          emit_byte({1'b0, bit_hold});
          bit_hold = '0;
          bit_cnt  = '0;
        end
        // mark only the final byte of this transaction; an empty tail marks nothing
        if (step_n > 0) begin
          r = step_buf[step_n-1];
          r.out_last = 1'b1;
          step_buf[step_n-1] = r;
        end
      end
      for (int i = 0; i < step_n; i++) exp_bytes.push_back(step_buf[i]);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) begin
        if (exp_bytes.size() == 0) begin
          $error("unexpected output byte %02h last %0b", out_data.out_byte, out_data.out_last);
          fail_count++;
        end else begin
          want = exp_bytes.pop_front();
          bytes_checked++;
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %02h actual %02h", want.out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last expected %0b actual %0b", want.out_last, out_data.out_last);
            fail_count++;
          end
        end
      end
    end
    exp_left = exp_bytes.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives the zero-run Huffman bit packer and reports the verdict
`timescale 1ns / 1ps
module tb_top;
  import zrbp_pkg::*;

  localparam int TABLE_SLOTS = 261;
  localparam int RUN_CAP     = 16662;
  localparam int RAND_ITEMS  = 130;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count;
  int exp_left;
  int bytes_checked;

  int tx_idle_pct = 9;
  int rx_idle_pct = 60;
  bit stall_request = 1'b0;
  bit stall_served  = 1'b0;
  int hold_left     = 0;
  int loads_sent    = 0;
  int bytes_sent    = 0;

  huffman_zero_run_bit_packer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  zero_run_code_checker watch (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .exp_left      (exp_left),
    .bytes_checked (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 12) return 32;
    if (r < 17) return $urandom_range(33, 63);
    return $urandom_range(1, 24);
  endfunction

  task automatic push(input in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_load(input logic [8:0] idx, input logic [31:0] code, input int len);
    in_item_t it;
    it.mode         = MODE_LOAD;
    it.table_index  = idx;
    it.code_value   = code;
    it.code_length  = 6'(len);
    it.data_byte    = 8'($urandom);
    it.end_of_block = 1'($urandom);
    push(it);
    loads_sent++;
  endtask

  task automatic send_data(input logic [7:0] b, input logic eob);
    in_item_t it;
    it.mode         = MODE_DATA;
    it.table_index  = 9'($urandom);
    it.code_value   = $urandom;
    it.code_length  = 6'($urandom);
    it.data_byte    = b;
    it.end_of_block = eob;
    push(it);
    bytes_sent++;
  endtask

  task automatic send_zero_run(input int n, input logic eob);
    for (int i = 0; i < n; i++) send_data(8'd0, eob && (i == n - 1));
  endtask

  initial begin
    int rand_cnt;
    int r;
    int run_pick;
    int run_n;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every slot before any data byte can read it
    for (int s = 0; s < TABLE_SLOTS; s++) send_load(9'(s), $urandom, rand_len());

    // zero-length slot used by a single zero
    send_load(SLOT_ZERO, $urandom, 0);
    send_data(8'd0, 1'b0);
    send_data(8'hff, 1'b0);
    // overlong length saturates to 32 bits
    send_load(9'd255, 32'hffff_ffff, 63);
    send_data(8'hff, 1'b0);
    send_load(9'd1, 32'h0000_0000, 32);
    send_data(8'h01, 1'b1);
    // out-of-range slots must be ignored
    send_load(9'd261, $urandom, 5);
    send_load(9'd511, 32'hffff_ffff, 5);
    // end of block with nothing to emit
    send_load(9'd7, $urandom, 0);
    send_data(8'h07, 1'b1);
    // reload a run slot while the run is still open
    send_zero_run(3, 1'b0);
    send_load(SLOT_RUN_SHORT, $urandom, 9);
    send_zero_run(2, 1'b0);
    send_data(8'h80, 1'b0);
    // run closed by end of block
    send_zero_run(2, 1'b1);
    send_load(SLOT_ZERO, $urandom, 3);
    send_data(8'h00, 1'b1);

    rand_cnt = 0;
    while (rand_cnt < RAND_ITEMS) begin
      if (rand_cnt >= 87 && tx_idle_pct != 0) begin
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_request = 1'b1;
      end else if (rand_cnt >= 43 && rand_cnt < 87) begin
        tx_idle_pct = 60;
        rx_idle_pct = 9;
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        if ($urandom_range(0, 99) < 15) begin
          send_load(9'($urandom_range(261, 511)), $urandom, rand_len());
        end else begin
          send_load(9'($urandom_range(0, TABLE_SLOTS - 1)), $urandom, rand_len());
        end
        rand_cnt++;
      end else if (r < 20) begin
        send_data(8'($urandom), 1'b1);
        rand_cnt++;
      end else if (r < 40) begin
        run_pick = $urandom_range(0, 10);
        case (run_pick)
          0: run_n = 1;
          1: run_n = 2;
          2: run_n = 3;
          3: run_n = 6;
          4: run_n = 7;
          5: run_n = 22;
          6: run_n = 23;
          7: run_n = ($urandom_range(0, 3) == 0) ? 278 : $urandom_range(8, 30);
          8: run_n = ($urandom_range(0, 3) == 0) ? 279 : $urandom_range(3, 12);
          default: run_n = $urandom_range(1, 30);
        endcase
        send_zero_run(run_n, 1'b0);
        send_data(8'($urandom_range(1, 255)), ($urandom_range(0, 4) == 0));
        rand_cnt += 2;
      end else begin
        if ($urandom_range(0, 9) == 0) send_data(8'd0, 1'b0);
        else send_data(8'($urandom_range(1, 255)), 1'b0);
        rand_cnt++;
      end
    end

    // run at the cap codes at once; the zeros after it open a new run
    send_zero_run(RUN_CAP + 3, 1'b1);
    in_valid <= 1'b0;

    // let the checker account for the last transaction before polling
    @(posedge clk);
    while (exp_left != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d table loads and %0d data bytes; checked %0d packed bytes",
             loads_sent, bytes_sent, bytes_checked);
    $display("Covered all run classes, run cap, empty tail, overlong codes and a long stall");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/zrbp_pkg.sv
rtl/core/zrbp_code_mem.sv
rtl/core/zrbp_drain.sv
rtl/core/huffman_zero_run_bit_packer_unit.sv
tb/zero_run_code_checker.sv
tb/tb_top.sv
